// ----- rtl/wavhdr_pkg.sv -----
// Shared types, codes and constants of the WAV header parser.
`default_nettype none
package wavhdr_pkg;

  // Field widths.
  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 32;
  localparam int CH_W    = 2;
  localparam int BITS_W  = 5;
  localparam int RATE_W  = 16;
  localparam int KIND_W  = 3;

  // Configuration port: byte address bits and data width.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_MIN_DATA = 1'b0;
  localparam logic [WORD_W-1:0] MIN_DATA_RESET = 32'd1024;

  // Input commands.
  localparam logic [CMD_W-1:0] CMD_BYTE    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_END     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

  // Chunk kinds.
  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FMT     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DATA    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SKIP    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FMT_BAD = 3'd5;

  // Four-character codes, first character in the low byte.
  localparam logic [WORD_W-1:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [WORD_W-1:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [WORD_W-1:0] TAG_DATA = 32'h6174_6164;
  localparam logic [WORD_W-1:0] TAG_DISP = 32'h5053_4944;
  localparam logic [WORD_W-1:0] TAG_LIST = 32'h5453_494C;
  localparam logic [WORD_W-1:0] TAG_FACT = 32'h7463_6166;

  // Limits on the padded fmt chunk size.
  localparam logic [WORD_W:0] FMT_MIN = 33'd16;
  localparam logic [WORD_W:0] FMT_MAX = 33'd100;

  // Status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // One result item as it leaves the parse logic.
  typedef struct packed {
    logic              status;
    logic [WORD_W-1:0] data_size;
    logic [CH_W-1:0]   channels;
    logic [BITS_W-1:0] bits_per_sample;
    logic [RATE_W-1:0] sample_rate;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/wavhdr_in_if.sv -----
// Input channel: one command and file byte per item.
`default_nettype none
interface wavhdr_in_if;
  logic                             valid;
  logic                             ready;
  logic [wavhdr_pkg::CMD_W-1:0]     command;
  logic [wavhdr_pkg::BYTE_W-1:0]    data_byte;

  modport source(output valid, output command, output data_byte, input ready);
  modport sink(input valid, input command, input data_byte, output ready);
endinterface
`default_nettype wire

// ----- rtl/wavhdr_out_if.sv -----
// Result channel: parse status and format values.
`default_nettype none
interface wavhdr_out_if;
  logic                             valid;
  logic                             ready;
  logic                             status;
  logic [wavhdr_pkg::WORD_W-1:0]    data_size;
  logic [wavhdr_pkg::CH_W-1:0]      channels;
  logic [wavhdr_pkg::BITS_W-1:0]    bits_per_sample;
  logic [wavhdr_pkg::RATE_W-1:0]    sample_rate;

  modport source(output valid, output status, output data_size, output channels,
                 output bits_per_sample, output sample_rate, input ready);
  modport sink(input valid, input status, input data_size, input channels,
               input bits_per_sample, input sample_rate, output ready);
endinterface
`default_nettype wire

// ----- rtl/wavhdr_cfg.sv -----
// APB register block holding the minimum data chunk size.
`default_nettype none
module wavhdr_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [wavhdr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [wavhdr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [wavhdr_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                     pready,
  output logic      [wavhdr_pkg::WORD_W-1:0]       min_data_bytes
);

  logic [wavhdr_pkg::WORD_W-1:0] min_data_r;
  logic                          hit;

  // Register index is the word address; only the first one exists.
  assign hit    = (paddr[wavhdr_pkg::CFG_ADDR_W-1:2] == wavhdr_pkg::REG_MIN_DATA);
  assign pready = 1'b1;

  // Write in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_data_r <= wavhdr_pkg::MIN_DATA_RESET;
    end else if (psel && penable && pwrite && hit) begin
      min_data_r <= pwdata;
    end
  end

  assign prdata         = hit ? min_data_r : '0;
  assign min_data_bytes = min_data_r;

endmodule
`default_nettype wire

// ----- rtl/wavhdr_core.sv -----
// Input register, parse state and the per-item parse step.
`default_nettype none
module wavhdr_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [wavhdr_pkg::CMD_W-1:0]      in_command,
  input  wire logic [wavhdr_pkg::BYTE_W-1:0]     in_byte,
  input  wire logic [wavhdr_pkg::WORD_W-1:0]     min_data_bytes,
  input  wire logic                              res_free,
  output logic                                   res_valid,
  output wavhdr_pkg::result_t                    res
);

  localparam int PH_W = 3;
  localparam logic [PH_W-1:0] PH_HEADER = 3'd0;
  localparam logic [PH_W-1:0] PH_CHUNK  = 3'd1;
  localparam logic [PH_W-1:0] PH_BODY   = 3'd2;
  localparam logic [PH_W-1:0] PH_SKIP   = 3'd3;
  localparam logic [PH_W-1:0] PH_DONE   = 3'd4;

  localparam int W = wavhdr_pkg::WORD_W;

  // Input register.
  logic                            s1_vld_r;
  logic [wavhdr_pkg::CMD_W-1:0]    s1_cmd_r;
  logic [wavhdr_pkg::BYTE_W-1:0]   s1_byte_r;
  logic                            go;

  // Parse state.
  logic [PH_W-1:0]                 phase_r, phase_nxt;
  logic [W-1:0]                    cnt_r, cnt_nxt;
  logic [W-1:0]                    shift_r, shift_nxt;
  logic [W-1:0]                    len_r, len_nxt;
  logic [wavhdr_pkg::KIND_W-1:0]   kind_r, kind_nxt;
  logic [wavhdr_pkg::CH_W-1:0]     ch_r, ch_nxt;
  logic [wavhdr_pkg::BITS_W-1:0]   bits_r, bits_nxt;
  logic [wavhdr_pkg::RATE_W-1:0]   rate_r, rate_nxt;

  // Step helpers.
  logic [W-1:0]                    shifted;
  logic [W-1:0]                    body_word;
  logic [wavhdr_pkg::KIND_W-1:0]   body_kind;
  logic [W:0]                      cnt_end;
  logic [W:0]                      len_pad;
  logic [W:0]                      new_pad;
  logic                            fin;
  logic                            fin_status;
  logic [W-1:0]                    fin_size;
  logic [7:0]                      body_ch;
  logic [7:0]                      body_bits;

  // The step runs when the input register holds an item and the result register can take what it may produce.
  assign go       = s1_vld_r && res_free;
  assign in_ready = !s1_vld_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_cmd_r  <= in_command;
      s1_byte_r <= in_byte;
    end
  end

  assign shifted = {s1_byte_r, shift_r[W-1:8]};
  assign cnt_end = {1'b0, cnt_r} + {{W{1'b0}}, 1'b1};
  assign len_pad = {1'b0, len_r} + {{W{1'b0}}, len_r[0]};
  assign new_pad = {1'b0, shifted} + {{W{1'b0}}, shifted[0]};

  // Fmt body: pick out the format byte, channels, rate and bits per sample.
  always_comb begin
    body_word = shift_r;
    body_kind = kind_r;
    unique case (cnt_r)
      32'd0:   if (s1_byte_r != 8'd1) body_kind = wavhdr_pkg::KIND_FMT_BAD;
      32'd2:   body_word[23:16] = s1_byte_r;
      32'd4:   body_word[7:0]   = s1_byte_r;
      32'd5:   body_word[15:8]  = s1_byte_r;
      32'd14:  body_word[31:24] = s1_byte_r;
      default: body_word = shift_r;
    endcase
  end

  assign body_ch   = body_word[23:16];
  assign body_bits = body_word[31:24];

  // One parse step for the item in the input register.
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    shift_nxt  = shift_r;
    len_nxt    = len_r;
    kind_nxt   = kind_r;
    ch_nxt     = ch_r;
    bits_nxt   = bits_r;
    rate_nxt   = rate_r;
    fin        = 1'b0;
    fin_status = wavhdr_pkg::STATUS_BAD;
    fin_size   = '0;
    if (s1_cmd_r == wavhdr_pkg::CMD_RESTART) begin
      phase_nxt = PH_HEADER;
      cnt_nxt   = '0;
      shift_nxt = '0;
      len_nxt   = '0;
      kind_nxt  = wavhdr_pkg::KIND_NONE;
      ch_nxt    = '0;
      bits_nxt  = '0;
      rate_nxt  = '0;
    end else if (s1_cmd_r == wavhdr_pkg::CMD_UNUSED || phase_r == PH_DONE) begin
      phase_nxt = phase_r;
    end else if (s1_cmd_r == wavhdr_pkg::CMD_END) begin
      fin = 1'b1;
    end else begin
      unique case (phase_r)
        PH_HEADER: begin
          shift_nxt = shifted;
          if (cnt_r >= 32'd11) begin
            cnt_nxt   = '0;
            phase_nxt = PH_CHUNK;
            if (shifted != wavhdr_pkg::TAG_WAVE) fin = 1'b1;
          end else begin
            cnt_nxt = cnt_end[W-1:0];
          end
        end
        PH_CHUNK: begin
          shift_nxt = shifted;
          // Chunk id is complete after the fourth byte.
          if (cnt_r == 32'd3) begin
            if (shifted == wavhdr_pkg::TAG_FMT) begin
              kind_nxt = wavhdr_pkg::KIND_FMT;
            end else if (shifted == wavhdr_pkg::TAG_DATA) begin
              kind_nxt = wavhdr_pkg::KIND_DATA;
            end else if (shifted == wavhdr_pkg::TAG_DISP || shifted == wavhdr_pkg::TAG_LIST ||
                         shifted == wavhdr_pkg::TAG_FACT) begin
              kind_nxt = wavhdr_pkg::KIND_SKIP;
            end else begin
              kind_nxt = wavhdr_pkg::KIND_UNKNOWN;
            end
          end
          // Size is complete after the eighth byte.
          if (cnt_r >= 32'd7) begin
            len_nxt = shifted;
            cnt_nxt = '0;
            unique case (kind_r)
              wavhdr_pkg::KIND_FMT: begin
                if (new_pad < wavhdr_pkg::FMT_MIN || new_pad > wavhdr_pkg::FMT_MAX) begin
                  fin = 1'b1;
                end else begin
                  shift_nxt = '0;
                  phase_nxt = PH_BODY;
                end
              end
              wavhdr_pkg::KIND_DATA: begin
                fin = 1'b1;
                if (shifted >= min_data_bytes) begin
                  fin_status = wavhdr_pkg::STATUS_OK;
                  fin_size   = shifted;
                end
              end
              wavhdr_pkg::KIND_SKIP: begin
                phase_nxt = (new_pad == '0) ? PH_CHUNK : PH_SKIP;
              end
              default: fin = 1'b1;
            endcase
          end else begin
            cnt_nxt = cnt_end[W-1:0];
          end
        end
        PH_BODY: begin
          shift_nxt = body_word;
          kind_nxt  = body_kind;
          if (cnt_end >= len_pad) begin
            if (body_kind != wavhdr_pkg::KIND_FMT || (body_ch != 8'd1 && body_ch != 8'd2) ||
                (body_bits != 8'd8 && body_bits != 8'd16)) begin
              fin = 1'b1;
            end else begin
              ch_nxt    = body_ch[wavhdr_pkg::CH_W-1:0];
              bits_nxt  = body_bits[wavhdr_pkg::BITS_W-1:0];
              rate_nxt  = body_word[wavhdr_pkg::RATE_W-1:0];
              phase_nxt = PH_CHUNK;
              cnt_nxt   = '0;
            end
          end else begin
            cnt_nxt = cnt_end[W-1:0];
          end
        end
        PH_SKIP: begin
          if (cnt_end >= len_pad) begin
            phase_nxt = PH_CHUNK;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_end[W-1:0];
          end
        end
        default: phase_nxt = PH_DONE;
      endcase
    end
    if (fin) phase_nxt = PH_DONE;
  end

  // State update on each processed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      cnt_r   <= '0;
      shift_r <= '0;
      len_r   <= '0;
      kind_r  <= wavhdr_pkg::KIND_NONE;
      ch_r    <= '0;
      bits_r  <= '0;
      rate_r  <= '0;
    end else if (go) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      shift_r <= shift_nxt;
      len_r   <= len_nxt;
      kind_r  <= kind_nxt;
      ch_r    <= ch_nxt;
      bits_r  <= bits_nxt;
      rate_r  <= rate_nxt;
    end
  end

  // Result carries the stored format values, which a finishing step never changes.
  assign res_valid           = go && fin;
  assign res.status          = fin_status;
  assign res.data_size       = fin_size;
  assign res.channels        = ch_r;
  assign res.bits_per_sample = bits_r;
  assign res.sample_rate     = rate_r;

endmodule
`default_nettype wire

// ----- rtl/wavhdr_outreg.sv -----
// Result register between the parse step and the result channel.
`default_nettype none
module wavhdr_outreg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                res_valid,
  input  wire wavhdr_pkg::result_t res,
  output logic                     res_free,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output wavhdr_pkg::result_t      out_res
);

  logic                 out_vld_r;
  wavhdr_pkg::result_t  out_res_r;

  // The register is free when empty or when its item leaves this cycle.
  assign res_free = !out_vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_valid) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_res_r;

endmodule
`default_nettype wire

// ----- rtl/wav_header_chunk_parser.sv -----
// Top level of the WAV header parser: channels, register block and parse pipeline.
//
//   Channel   Dir  Handshake             Carries
//   in_ch     in   valid/ready           command, data_byte
//   out_ch    out  valid/ready           status, data_size, channels, bits_per_sample,
//                                        sample_rate
//   cfg (APB) in   psel/penable/pready   min_data_bytes at byte address 0
//
// One item is accepted per cycle while the result register is free or being emptied. An
// item enters the input register when accepted, and the parse step between the two
// registers loads any result that the item causes into the result register once that
// register is free; the result register drives out_ch.
// rst_n is synchronous and active low; it clears the parse and sets min_data_bytes to 1024.
// A stalled result holds in the result register; the input register keeps accepting
// while the result register is free or being emptied.
`default_nettype none
module wav_header_chunk_parser (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  wavhdr_in_if.sink                                in_ch,
  wavhdr_out_if.source                             out_ch,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [wavhdr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [wavhdr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [wavhdr_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                     pready
);

  logic [wavhdr_pkg::WORD_W-1:0] min_data_bytes;
  logic                          res_valid;
  logic                          res_free;
  wavhdr_pkg::result_t           res;
  wavhdr_pkg::result_t           out_res;

  // Configuration registers.
  wavhdr_cfg u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .min_data_bytes (min_data_bytes)
  );

  // Input register and parse step.
  wavhdr_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_command     (in_ch.command),
    .in_byte        (in_ch.data_byte),
    .min_data_bytes (min_data_bytes),
    .res_free       (res_free),
    .res_valid      (res_valid),
    .res            (res)
  );

  // Result register.
  wavhdr_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_free  (res_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.status          = out_res.status;
  assign out_ch.data_size       = out_res.data_size;
  assign out_ch.channels        = out_res.channels;
  assign out_ch.bits_per_sample = out_res.bits_per_sample;
  assign out_ch.sample_rate     = out_res.sample_rate;

endmodule
`default_nettype wire

// ----- rtl/wavhdr_chk.sv -----
// Port-level checker for the WAV header parser, bound to the top level.
`default_nettype none
module wavhdr_chk (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic                              status,
  input wire logic [wavhdr_pkg::WORD_W-1:0]     data_size,
  input wire logic [wavhdr_pkg::CH_W-1:0]       channels,
  input wire logic [wavhdr_pkg::BITS_W-1:0]     bits_per_sample
);

  // No result item is offered right after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // A stalled result item keeps its status and size.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(data_size))
    else $error("stalled result changed");

  // An invalid result reports no data size.
  a_bad_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == wavhdr_pkg::STATUS_BAD |-> data_size == '0)
    else $error("invalid result with nonzero size");

  // Format values are either all unset or a legal committed pair.
  a_fmt_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (channels == '0 && bits_per_sample == '0) ||
                  ((channels == 2'd1 || channels == 2'd2) &&
                   (bits_per_sample == 5'd8 || bits_per_sample == 5'd16)))
    else $error("inconsistent format values");

endmodule

bind wav_header_chunk_parser wavhdr_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .status          (out_ch.status),
  .data_size       (out_ch.data_size),
  .channels        (out_ch.channels),
  .bits_per_sample (out_ch.bits_per_sample)
);
`default_nettype wire
